### rtl/hpmc_pkg.sv
package hpmc_pkg;

	// Sizes of the prediction store and the block.
	localparam int MAX_SEGMENTS = 2;
	localparam int MAX_ROWS     = 16;
	localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// Pixel and field widths.
	localparam int PIX_W      = 8;
	localparam int SEG_PIX    = 8;
	localparam int SEG_BITS   = PIX_W * SEG_PIX;
	localparam int ROW_CNT_W  = 5;
	localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_X           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_Y           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS_PER_ROW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS       = 3'd4;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register set.
	typedef struct packed {
		logic                 half_x;
		logic                 half_y;
		logic                 average_mode;
		logic [1:0]           segments_per_row;
		logic [ROW_CNT_W-1:0] block_rows;
	} cfg_t;

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic [SEG_BITS-1:0] src_pixels;
		logic [PIX_W-1:0]    src_next_pixel;
		logic [SEG_BITS-1:0] prev_pixels;
		logic [PIX_W-1:0]    prev_next_pixel;
		logic [SEG_BITS-1:0] dst_pixels;
		logic                half_x;
		logic                half_y;
		logic                average_mode;
		logic                last;
	} item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic nonempty;
	} queue_status_t;

endpackage

### rtl/hpmc_front.sv
module hpmc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpmc_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hpmc_pkg::SEG_BITS-1:0] src_pixels,
	input  logic [hpmc_pkg::PIX_W-1:0]    src_next_pixel,
	input  logic [hpmc_pkg::SEG_BITS-1:0] dst_pixels,
	input  hpmc_pkg::queue_status_t       q_status,
	output logic                          push,
	output hpmc_pkg::item_t               push_item
);

	logic [hpmc_pkg::SEG_W-1:0]     seg_idx_q;
	logic [hpmc_pkg::ROW_CNT_W-1:0] row_count_q;
	logic [hpmc_pkg::SEG_BITS-1:0]  prev_pix_q  [hpmc_pkg::MAX_SEGMENTS];
	logic [hpmc_pkg::PIX_W-1:0]     prev_next_q [hpmc_pkg::MAX_SEGMENTS];

	logic [1:0]                     spr;
	logic [hpmc_pkg::ROW_CNT_W-1:0] rows;
	logic [hpmc_pkg::ROW_CNT_W-1:0] final_row;
	logic [hpmc_pkg::SEG_W-1:0]     spr_m1;
	logic [hpmc_pkg::SEG_W-1:0]     seg;
	logic                           last_seg;
	logic                           produce;
	logic                           last;
	logic                           accept;

	// Clamp the block shape to the supported range.
	always_comb begin
		priority if (cfg.segments_per_row == 2'd0) begin
			spr = 2'd1;
		end else if (int'(cfg.segments_per_row) > hpmc_pkg::MAX_SEGMENTS) begin
			spr = 2'(hpmc_pkg::MAX_SEGMENTS);
		end else begin
			spr = cfg.segments_per_row;
		end
		priority if (cfg.block_rows == '0) begin
			rows = hpmc_pkg::ROW_CNT_W'(1);
		end else if (int'(cfg.block_rows) > hpmc_pkg::MAX_ROWS) begin
			rows = hpmc_pkg::ROW_CNT_W'(hpmc_pkg::MAX_ROWS);
		end else begin
			rows = cfg.block_rows;
		end
	end

	// Classify the request: segment slot, priming row and end of block.
	always_comb begin
		spr_m1    = hpmc_pkg::SEG_W'(spr - 2'd1);
		seg       = (int'(seg_idx_q) >= int'(spr)) ? spr_m1 : seg_idx_q;
		last_seg  = (seg == spr_m1);
		final_row = rows - hpmc_pkg::ROW_CNT_W'(1)
		          + {{(hpmc_pkg::ROW_CNT_W-1){1'b0}}, cfg.half_y};
		produce   = !(cfg.half_y && (row_count_q == '0));
		last      = produce && last_seg && (row_count_q >= final_row);
	end

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && produce;

	// Everything the back needs travels with the request.
	always_comb begin
		push_item.src_pixels      = src_pixels;
		push_item.src_next_pixel  = src_next_pixel;
		push_item.prev_pixels     = prev_pix_q[seg];
		push_item.prev_next_pixel = prev_next_q[seg];
		push_item.dst_pixels      = dst_pixels;
		push_item.half_x          = cfg.half_x;
		push_item.half_y          = cfg.half_y;
		push_item.average_mode    = cfg.average_mode;
		push_item.last            = last;
	end

	// Row store and block position, updated on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q   <= '0;
			row_count_q <= '0;
			for (int s = 0; s < hpmc_pkg::MAX_SEGMENTS; s++) begin
				prev_pix_q[s]  <= '0;
				prev_next_q[s] <= '0;
			end
		end else if (accept) begin
			prev_pix_q[seg]  <= src_pixels;
			prev_next_q[seg] <= src_next_pixel;
			if (last) begin
				seg_idx_q   <= '0;
				row_count_q <= '0;
			end else if (last_seg) begin
				seg_idx_q <= '0;
				if (row_count_q < hpmc_pkg::ROW_CNT_MAX) begin
					row_count_q <= row_count_q + hpmc_pkg::ROW_CNT_W'(1);
				end
			end else begin
				seg_idx_q <= seg + hpmc_pkg::SEG_W'(1);
			end
		end
	end

endmodule

### rtl/hpmc_queue.sv
module hpmc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  hpmc_pkg::item_t         push_item,
	input  logic                    pop,
	output hpmc_pkg::item_t         head_item,
	output hpmc_pkg::queue_status_t q_status
);

	hpmc_pkg::item_t             entry_q [hpmc_pkg::QUEUE_DEPTH];
	logic [hpmc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hpmc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hpmc_pkg::QCNT_W-1:0] count_q;

	function automatic logic [hpmc_pkg::QPTR_W-1:0] next_ptr(
		input logic [hpmc_pkg::QPTR_W-1:0] ptr
	);
		return (ptr == hpmc_pkg::QPTR_W'(hpmc_pkg::QUEUE_DEPTH - 1))
		       ? '0 : ptr + hpmc_pkg::QPTR_W'(1);
	endfunction

	assign head_item         = entry_q[rd_ptr_q];
	assign q_status.full     = (count_q == hpmc_pkg::QCNT_W'(hpmc_pkg::QUEUE_DEPTH));
	assign q_status.nonempty = (count_q != '0);

	// Request storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + hpmc_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - hpmc_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/hpmc_back.sv
module hpmc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hpmc_pkg::item_t               head_item,
	input  hpmc_pkg::queue_status_t       q_status,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hpmc_pkg::SEG_BITS-1:0] pred_pixels,
	output logic                          last_of_block
);

	localparam int ROW_BITS = hpmc_pkg::SEG_BITS + hpmc_pkg::PIX_W;

	logic                          out_valid_q;
	logic [hpmc_pkg::SEG_BITS-1:0] pred_q;
	logic                          last_q;
	logic [ROW_BITS-1:0]           cur_row;
	logic [ROW_BITS-1:0]           prev_row;
	logic [hpmc_pkg::SEG_BITS-1:0] pred_next;

	// One output pixel: interpolation, then the optional destination average.
	function automatic logic [hpmc_pkg::PIX_W-1:0] pixel_pred(
		input logic [hpmc_pkg::PIX_W-1:0] a,
		input logic [hpmc_pkg::PIX_W-1:0] b,
		input logic [hpmc_pkg::PIX_W-1:0] c,
		input logic [hpmc_pkg::PIX_W-1:0] d,
		input logic [hpmc_pkg::PIX_W-1:0] dst,
		input logic                       hx,
		input logic                       hy,
		input logic                       avg
	);
		logic [hpmc_pkg::PIX_W+1:0] sum4;
		logic [hpmc_pkg::PIX_W:0]   sum2;
		logic [hpmc_pkg::PIX_W:0]   sumd;
		logic [hpmc_pkg::PIX_W-1:0] p;
		sum4 = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d}
		     + (hpmc_pkg::PIX_W+2)'(2);
		sum2 = (hx ? {1'b0, d} : {1'b0, a}) + {1'b0, c} + (hpmc_pkg::PIX_W+1)'(1);
		unique case ({hx, hy})
			2'b11:   p = sum4[hpmc_pkg::PIX_W+1:2];
			2'b10,
			2'b01:   p = sum2[hpmc_pkg::PIX_W:1];
			default: p = c;
		endcase
		sumd = {1'b0, p} + {1'b0, dst} + (hpmc_pkg::PIX_W+1)'(1);
		return avg ? sumd[hpmc_pkg::PIX_W:1] : p;
	endfunction

	assign cur_row  = {head_item.src_next_pixel, head_item.src_pixels};
	assign prev_row = {head_item.prev_next_pixel, head_item.prev_pixels};

	// Eight pixels side by side.
	always_comb begin
		for (int i = 0; i < hpmc_pkg::SEG_PIX; i++) begin
			pred_next[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W] = pixel_pred(
				prev_row[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W],
				prev_row[(i+1)*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W],
				cur_row[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W],
				cur_row[(i+1)*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W],
				head_item.dst_pixels[i*hpmc_pkg::PIX_W +: hpmc_pkg::PIX_W],
				head_item.half_x,
				head_item.half_y,
				head_item.average_mode);
		end
	end

	// Take the next request whenever the output register is free or drains.
	assign pop = q_status.nonempty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_status.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pred_q <= pred_next;
			last_q <= head_item.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign pred_pixels   = pred_q;
	assign last_of_block = last_q;

endmodule

### rtl/half_pel_motion_compensation.sv
// Half-pel motion compensation: builds an 8- or 16-pixel-wide prediction
// block from reference rows at full or half-pel offsets.
// Input channel: one request per 8-pixel reference segment (src_pixels,
// the pixel to its right in src_next_pixel, and dst_pixels for average
// mode), accepted when in_valid and in_ready are both high.
// Output channel: one result per producing request, pred_pixels with
// last_of_block set on the final segment of the block.
// Configuration: cfg_index selects half_x, half_y, average_mode,
// segments_per_row or block_rows; cfg_ready is always high. Write it only
// while no request is in flight.
// Throughput is one request per cycle while in_ready is high. An accepted
// request is written into the queue, then taken through the averaging adders
// into the output register (out_valid) once that register is free or drains.
// With half_y set, the first reference row of a block only loads the row
// store and gives no result.
// Reset clears the row store, the block position and the queue, and sets
// the registers to full-pel copy of a 16x16 block. When the receiver holds
// out_ready low the output keeps its result, the queue fills, and in_ready
// drops once both queue entries are taken.
module half_pel_motion_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hpmc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [hpmc_pkg::SEG_BITS-1:0]   src_pixels,
	input  logic [hpmc_pkg::PIX_W-1:0]      src_next_pixel,
	input  logic [hpmc_pkg::SEG_BITS-1:0]   dst_pixels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [hpmc_pkg::SEG_BITS-1:0]   pred_pixels,
	output logic                            last_of_block
);

	hpmc_pkg::cfg_t          cfg_q;
	hpmc_pkg::queue_status_t q_status;
	hpmc_pkg::item_t         push_item;
	hpmc_pkg::item_t         head_item;
	logic                    push;
	logic                    pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_x           <= 1'b0;
			cfg_q.half_y           <= 1'b0;
			cfg_q.average_mode     <= 1'b0;
			cfg_q.segments_per_row <= 2'd2;
			cfg_q.block_rows       <= hpmc_pkg::ROW_CNT_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hpmc_pkg::REG_HALF_X:           cfg_q.half_x <= cfg_data[0];
				hpmc_pkg::REG_HALF_Y:           cfg_q.half_y <= cfg_data[0];
				hpmc_pkg::REG_AVERAGE_MODE:     cfg_q.average_mode <= cfg_data[0];
				hpmc_pkg::REG_SEGMENTS_PER_ROW: cfg_q.segments_per_row <= cfg_data[1:0];
				hpmc_pkg::REG_BLOCK_ROWS:
					cfg_q.block_rows <= cfg_data[hpmc_pkg::ROW_CNT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	hpmc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.src_pixels     (src_pixels),
		.src_next_pixel (src_next_pixel),
		.dst_pixels     (dst_pixels),
		.q_status       (q_status),
		.push           (push),
		.push_item      (push_item)
	);

	hpmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	hpmc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_item     (head_item),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pred_pixels   (pred_pixels),
		.last_of_block (last_of_block)
	);

endmodule

### rtl/hpmc_checker.sv
module hpmc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hpmc_pkg::SEG_BITS-1:0] pred_pixels,
	input logic                          last_of_block
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pred_pixels)
		&& $stable(last_of_block))
		else $error("result changed while stalled");

	// A result only leaves once taken.
	a_out_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without being taken");

	// The input side backs up only behind a stalled output.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// Nothing comes out right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind half_pel_motion_compensation hpmc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.pred_pixels   (pred_pixels),
	.last_of_block (last_of_block)
);

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

	// Run shape.
	localparam int RANDOM_ITEMS   = 2000;
	localparam int DIR_ROWS       = 23;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT        = 300;
	localparam int HOLD_MIN_ITEMS = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	// Register indexes past the last defined one.
	localparam logic [hpmc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = hpmc_pkg::REG_BLOCK_ROWS + 3'd1;

	// Pixel patterns used by the directed requests.
	localparam logic [hpmc_pkg::SEG_BITS-1:0] ZERO64   = '0;
	localparam logic [hpmc_pkg::SEG_BITS-1:0] ALL_FF   = '1;
	localparam logic [hpmc_pkg::SEG_BITS-1:0] HALF     = 64'h8080_8080_8080_8080;
	localparam logic [hpmc_pkg::SEG_BITS-1:0] COUNT_UP = 64'h0123_4567_89AB_CDEF;

	// One predicted result.
	typedef struct packed {
		logic [hpmc_pkg::SEG_BITS-1:0] pixels;
		logic                          last;
	} pred_t;

	// One directed request, with an optional register setting applied first.
	typedef struct packed {
		logic                          set_cfg;
		logic [7:0]                    hx;
		logic [7:0]                    hy;
		logic [7:0]                    avg;
		logic [7:0]                    segs;
		logic [7:0]                    rows;
		logic [hpmc_pkg::SEG_BITS-1:0] src;
		logic [hpmc_pkg::PIX_W-1:0]    nxt;
		logic [hpmc_pkg::SEG_BITS-1:0] dst;
		logic                          typed;
		logic [hpmc_pkg::SEG_BITS-1:0] exp_pix;
		logic                          exp_last;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [hpmc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hpmc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [hpmc_pkg::SEG_BITS-1:0]   src_pixels;
	logic [hpmc_pkg::PIX_W-1:0]      src_next_pixel;
	logic [hpmc_pkg::SEG_BITS-1:0]   dst_pixels;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [hpmc_pkg::SEG_BITS-1:0]   pred_pixels;
	logic                            last_of_block;

	// Predictor state: register shadow, reference row store and block position.
	hpmc_pkg::cfg_t                shadow;
	logic [hpmc_pkg::SEG_BITS-1:0] row_store_pix [hpmc_pkg::MAX_SEGMENTS];
	logic [hpmc_pkg::PIX_W-1:0]    row_store_next [hpmc_pkg::MAX_SEGMENTS];
	int                            rows_taken;
	int                            seg_pos;

	pred_t pred_q [$];
	pred_t head_res;
	int    mismatches = 0;
	int    rnd_items;
	int    src_idle_pct;
	int    sink_idle_pct;
	int    stall_cycles = 0;
	logic  hold_armed;
	logic  hold_taken = 1'b0;
	int    hold_left = 0;

	// Directed requests: reset setting, each half-pel mode, average mode and
	// out-of-range register values.
	stim_row_t dir_tab [DIR_ROWS] = '{
		// Full-pel copy at the reset setting.
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'h00, ALL_FF, 1'b1, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ALL_FF, 8'hFF, ZERO64, 1'b1, ALL_FF, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  COUNT_UP, 8'h5A, 64'h3C3C_3C3C_3C3C_3C3C, 1'b1, COUNT_UP, 1'b0},
		// Horizontal half-pel, one-row 8-wide blocks: every result ends a block.
		'{1'b1, 8'h01, 8'h00, 8'h00, 8'h01, 8'h01,
		  ALL_FF, 8'hFF, ZERO64, 1'b1, ALL_FF, 1'b1},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'hFF, ALL_FF, 1'b1, 64'h8000_0000_0000_0000, 1'b1},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'hFF00_FF00_FF00_FF00, 8'h00, ZERO64, 1'b1, HALF, 1'b1},
		// Vertical half-pel, 16 wide, two rows: the first row only primes.
		'{1'b1, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02,
		  ALL_FF, 8'hFF, 64'h1111_2222_3333_4444, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ALL_FF, 8'hFF, ZERO64, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'h00, ALL_FF, 1'b1, HALF, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'h00, ALL_FF, 1'b1, HALF, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'hDEAD_BEEF_0BAD_F00D, 8'h77, 64'h1234_5678_9ABC_DEF0, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'h8899_AABB_CCDD_EEFF, 8'h01, ZERO64, 1'b0, ZERO64, 1'b0},
		// Four-point average combined with average mode.
		'{1'b1, 8'h01, 8'h01, 8'h01, 8'h02, 8'h01,
		  64'h0011_2233_4455_6677, 8'h88, ALL_FF, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'hF0E1_D2C3_B4A5_9687, 8'h78, ZERO64, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'h0F1E_2D3C_4B5A_6978, 8'h87, 64'hFFFF_0000_FFFF_0000, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ALL_FF, 8'hFF, ZERO64, 1'b0, ZERO64, 1'b0},
		// Zero width and zero height saturate to one segment and one row.
		'{1'b1, 8'h81, 8'h03, 8'h40, 8'hFC, 8'hE0,
		  ALL_FF, 8'hFF, ZERO64, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ALL_FF, 8'hFF, ZERO64, 1'b1, ALL_FF, 1'b1},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'h00, ALL_FF, 1'b0, ZERO64, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'h00, ALL_FF, 1'b1, ZERO64, 1'b1},
		// Oversized width and height saturate; average mode on a copy.
		'{1'b1, 8'h00, 8'h00, 8'h01, 8'h07, 8'h1F,
		  ALL_FF, 8'h00, ZERO64, 1'b1, HALF, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  ZERO64, 8'hFF, ALL_FF, 1'b1, HALF, 1'b0},
		'{1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  64'h7F80_01FE_55AA_C33C, 8'h99, 64'h0102_0304_0506_0708, 1'b0, ZERO64, 1'b0}
	};

	half_pel_motion_compensation uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.src_pixels     (src_pixels),
		.src_next_pixel (src_next_pixel),
		.dst_pixels     (dst_pixels),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pred_pixels    (pred_pixels),
		.last_of_block  (last_of_block)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pixel i of a segment; index 8 is the neighbor to its right.
	function automatic int pel(input logic [hpmc_pkg::SEG_BITS-1:0] pix,
			input logic [hpmc_pkg::PIX_W-1:0] nxt, input int i);
		if (i >= hpmc_pkg::SEG_PIX)
			return int'(nxt);
		return int'(pix[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W]);
	endfunction

	// Works out the result of one request and advances the block position.
	// Returns 0 for a priming request, which gives no result.
	function automatic logic predict_segment(input logic [hpmc_pkg::SEG_BITS-1:0] src,
			input logic [hpmc_pkg::PIX_W-1:0] nxt, input logic [hpmc_pkg::SEG_BITS-1:0] dst,
			output pred_t res);
		int segs, rows, seg, final_row, i, a, b, c, d, p;
		logic last_seg, produce, last;
		logic [hpmc_pkg::SEG_BITS-1:0] pix;
		segs = int'(shadow.segments_per_row);
		if (segs < 1) segs = 1;
		if (segs > hpmc_pkg::MAX_SEGMENTS) segs = hpmc_pkg::MAX_SEGMENTS;
		rows = int'(shadow.block_rows);
		if (rows < 1) rows = 1;
		if (rows > hpmc_pkg::MAX_ROWS) rows = hpmc_pkg::MAX_ROWS;
		seg = seg_pos;
		if (seg >= segs) seg = segs - 1;
		last_seg = (seg == segs - 1);
		final_row = rows - 1 + int'(shadow.half_y);
		produce = !(shadow.half_y && rows_taken == 0);
		last = 1'b0;
		pix = '0;
		if (produce) begin
			for (i = 0; i < hpmc_pkg::SEG_PIX; i++) begin
				c = pel(src, nxt, i);
				d = pel(src, nxt, i + 1);
				a = pel(row_store_pix[seg], row_store_next[seg], i);
				b = pel(row_store_pix[seg], row_store_next[seg], i + 1);
				if (shadow.half_x && shadow.half_y)
					p = (a + b + c + d + 2) >> 2;
				else if (shadow.half_x)
					p = (c + d + 1) >> 1;
				else if (shadow.half_y)
					p = (a + c + 1) >> 1;
				else
					p = c;
				if (shadow.average_mode)
					p = (p + int'(dst[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W]) + 1) >> 1;
				pix[hpmc_pkg::PIX_W*i +: hpmc_pkg::PIX_W] = hpmc_pkg::PIX_W'(p);
			end
			last = last_seg && (rows_taken >= final_row);
		end
		row_store_pix[seg] = src;
		row_store_next[seg] = nxt;
		if (last) begin
			rows_taken = 0;
			seg_pos = 0;
		end else if (last_seg) begin
			seg_pos = 0;
			if (rows_taken < int'(hpmc_pkg::ROW_CNT_MAX))
				rows_taken++;
		end else begin
			seg_pos = seg + 1;
		end
		res.pixels = pix;
		res.last = last;
		return produce;
	endfunction

	// Random upper bits above the meaningful width of a register value.
	function automatic logic [hpmc_pkg::CFG_DATA_W-1:0] with_junk(
			input logic [hpmc_pkg::CFG_DATA_W-1:0] v, input int w);
		logic [hpmc_pkg::CFG_DATA_W-1:0] r;
		int k;
		r = v;
		for (k = w; k < hpmc_pkg::CFG_DATA_W; k++)
			r[k] = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// Pixels biased toward the extremes so that rounding edges get hit.
	function automatic logic [hpmc_pkg::SEG_BITS-1:0] rand_pixels();
		logic [hpmc_pkg::SEG_BITS-1:0] v;
		int k, sel;
		for (k = 0; k < hpmc_pkg::SEG_PIX; k++) begin
			sel = $urandom_range(0, 5);
			if (sel == 0)
				v[hpmc_pkg::PIX_W*k +: hpmc_pkg::PIX_W] = '0;
			else if (sel == 1)
				v[hpmc_pkg::PIX_W*k +: hpmc_pkg::PIX_W] = '1;
			else
				v[hpmc_pkg::PIX_W*k +: hpmc_pkg::PIX_W] =
					hpmc_pkg::PIX_W'($urandom_range(0, 255));
		end
		return v;
	endfunction

	// Offers one register write and updates the shadow once it is taken.
	// The caller lowers cfg_valid after the last write of a series.
	task automatic write_reg(input logic [hpmc_pkg::CFG_IDX_W-1:0] idx,
			input logic [hpmc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			hpmc_pkg::REG_HALF_X:           shadow.half_x = data[0];
			hpmc_pkg::REG_HALF_Y:           shadow.half_y = data[0];
			hpmc_pkg::REG_AVERAGE_MODE:     shadow.average_mode = data[0];
			hpmc_pkg::REG_SEGMENTS_PER_ROW: shadow.segments_per_row = data[1:0];
			hpmc_pkg::REG_BLOCK_ROWS:       shadow.block_rows = data[hpmc_pkg::ROW_CNT_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register; now and then also an index that holds nothing.
	task automatic apply_setting(input logic [7:0] hx, input logic [7:0] hy,
			input logic [7:0] avg, input logic [7:0] segs, input logic [7:0] rows);
		write_reg(hpmc_pkg::REG_HALF_X, hx);
		write_reg(hpmc_pkg::REG_HALF_Y, hy);
		write_reg(hpmc_pkg::REG_AVERAGE_MODE, avg);
		write_reg(hpmc_pkg::REG_SEGMENTS_PER_ROW, segs);
		write_reg(hpmc_pkg::REG_BLOCK_ROWS, rows);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE_LO + hpmc_pkg::CFG_IDX_W'($urandom_range(0, 2)),
				hpmc_pkg::CFG_DATA_W'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	// Drops the request line and waits until the block has drained.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pred_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Offers one request after a random gap, then predicts its result.
	task automatic push_segment(input logic [hpmc_pkg::SEG_BITS-1:0] src,
			input logic [hpmc_pkg::PIX_W-1:0] nxt, input logic [hpmc_pkg::SEG_BITS-1:0] dst,
			input logic typed, input pred_t typed_res);
		pred_t res;
		logic produce;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		src_pixels <= src;
		src_next_pixel <= nxt;
		dst_pixels <= dst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		produce = predict_segment(src, nxt, dst, res);
		if (produce)
			pred_q.push_back(typed ? typed_res : res);
	endtask

	// Receiver: checks each result and drives out_ready, with one long hold-off.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pred_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h last %b",
					$time, pred_pixels, last_of_block);
				mismatches++;
			end else begin
				head_res = pred_q.pop_front();
				if (pred_pixels !== head_res.pixels) begin
					$display("%0t: pred_pixels mismatch: expected %h, actual %h",
						$time, head_res.pixels, pred_pixels);
					mismatches++;
				end
				if (last_of_block !== head_res.last) begin
					$display("%0t: last_of_block mismatch: expected %b, actual %b",
						$time, head_res.last, last_of_block);
					mismatches++;
				end
			end
		end
		if (hold_armed && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Watchdog: ends the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Main sequence: reset, directed requests, then random phases.
	initial begin
		int r, mode, n, blocks, segs_eff, rows_eff, pick;
		stim_row_t row;
		pred_t typed_res;
		logic [7:0] hx, hy, avg, segs, rows;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		src_pixels = '0;
		src_next_pixel = '0;
		dst_pixels = '0;
		hold_armed = 1'b0;
		rnd_items = 0;
		src_idle_pct = 8;
		sink_idle_pct = 49;
		shadow = '{1'b0, 1'b0, 1'b0, 2'd2, 5'd16};
		for (r = 0; r < hpmc_pkg::MAX_SEGMENTS; r++) begin
			row_store_pix[r] = '0;
			row_store_next[r] = '0;
		end
		rows_taken = 0;
		seg_pos = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_tab[r];
			if (row.set_cfg) begin
				settle_idle();
				apply_setting(row.hx, row.hy, row.avg, row.segs, row.rows);
			end
			typed_res.pixels = row.exp_pix;
			typed_res.last = row.exp_last;
			push_segment(row.src, row.nxt, row.dst, row.typed, typed_res);
		end

		// Random phases: mostly whole blocks at a random setting, sometimes cut short or overrun.
		for (mode = 0; mode < 3; mode++) begin
			settle_idle();
			src_idle_pct = (mode == 0) ? 8 : ((mode == 1) ? 49 : 0);
			sink_idle_pct <= (mode == 0) ? 49 : ((mode == 1) ? 8 : 0);
			while (rnd_items < (mode + 1) * RANDOM_ITEMS / 3) begin
				settle_idle();
				hx = with_junk(8'($urandom_range(0, 1)), 1);
				hy = with_junk(8'($urandom_range(0, 1)), 1);
				avg = with_junk(8'($urandom_range(0, 1)), 1);
				if ($urandom_range(0, 9) == 0)
					segs = with_junk(($urandom_range(0, 1) == 0) ? 8'd0 : 8'd3, 2);
				else
					segs = with_junk(8'($urandom_range(1, hpmc_pkg::MAX_SEGMENTS)), 2);
				pick = $urandom_range(0, 9);
				if (pick < 6)
					rows = 8'($urandom_range(1, 4));
				else if (pick < 9)
					rows = 8'($urandom_range(1, hpmc_pkg::MAX_ROWS));
				else
					rows = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(17, 31));
				rows = with_junk(rows, hpmc_pkg::ROW_CNT_W);
				apply_setting(hx, hy, avg, segs, rows);
				segs_eff = int'(shadow.segments_per_row);
				if (segs_eff < 1) segs_eff = 1;
				if (segs_eff > hpmc_pkg::MAX_SEGMENTS) segs_eff = hpmc_pkg::MAX_SEGMENTS;
				rows_eff = int'(shadow.block_rows);
				if (rows_eff < 1) rows_eff = 1;
				if (rows_eff > hpmc_pkg::MAX_ROWS) rows_eff = hpmc_pkg::MAX_ROWS;
				blocks = $urandom_range(1, 3);
				n = blocks * (rows_eff + int'(shadow.half_y)) * segs_eff;
				if ($urandom_range(0, 6) == 0)
					n = $urandom_range(1, n + 3);
				// Start the long receiver hold-off on a burst long enough to fill the block.
				if (!hold_armed && rnd_items >= HOLD_AT) begin
					hold_armed <= 1'b1;
					if (n < HOLD_MIN_ITEMS)
						n = HOLD_MIN_ITEMS;
				end
				repeat (n) begin
					push_segment(rand_pixels(), hpmc_pkg::PIX_W'($urandom_range(0, 255)),
						rand_pixels(), 1'b0, '0);
					rnd_items++;
				end
			end
		end

		// Drain and report.
		settle_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/hpmc_pkg.sv
rtl/hpmc_front.sv
rtl/hpmc_queue.sv
rtl/hpmc_back.sv
rtl/half_pel_motion_compensation.sv
rtl/hpmc_checker.sv
tb/tb.sv
